// File: design/tocw_pkg.sv
package tocw_pkg;

	// Display geometry.
	localparam int COLUMNS   = 30;
	localparam int ROWS_NTSC = 12;
	localparam int ROWS_PAL  = 15;

	// A clear-line request writes at most this many cells.
	localparam int LINE_CAP = 30;
	localparam int LINE_CNT = (COLUMNS < LINE_CAP) ? COLUMNS : LINE_CAP;

	// Derived widths.
	localparam int CUR_W  = $clog2(ROWS_PAL * COLUMNS);
	localparam int ROW_W  = $clog2(ROWS_PAL + 1);
	localparam int POS_W  = $clog2(255 * COLUMNS + 256);
	localparam int CNT_W  = $clog2(LINE_CNT + 1);
	localparam int ADDR_W = 9;

	// Character codes.
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// Register byte addresses.
	localparam logic [2:0] REG_PAL_MODE = 3'd0;

	typedef enum logic [1:0] {
		MODE_PUT = 2'd0,
		MODE_SET = 2'd1,
		MODE_CLR = 2'd2
	} mode_t;

	typedef struct packed {
		logic [7:0] row;
		logic [7:0] column;
		logic [7:0] char_code;
		logic [1:0] mode;
	} item_t;

	// Work handed from the cursor logic to the result sequencer.
	typedef struct packed {
		logic              clr;
		logic [ADDR_W-1:0] base;
		logic [7:0]        data;
		logic [CNT_W-1:0]  count;
	} plan_t;

	typedef struct packed {
		logic              last;
		logic [7:0]        write_data;
		logic [ADDR_W-1:0] write_address;
		logic              clear_screen;
	} res_t;

endpackage

// File: design/text_overlay_cursor_writer.sv
// Text-mode cursor writer. Each input transaction carries a mode and its operands;
// the block keeps a cursor over a 30-column display of 12 (NTSC) or 15 (PAL) rows
// and turns printable characters and clear-line requests into display-memory
// write transactions, each marked last on the final one an input causes. A put
// at cursor 0 is preceded by a clear-screen transaction. Carriage return, line
// feed, set-cursor and ignored requests produce nothing. Inputs are taken one per
// cycle while the result sequencer keeps up; the single result sequencer drains one
// transaction per cycle into the output register while m_tready allows it. pal_mode
// is written through the APB port at byte address 0. Write it only while the block
// is idle; the block itself does not enforce this.
module text_overlay_cursor_writer (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: [1:0] mode, [9:2] char_code, [17:10] column, [25:18] row, [31:26] zero.
	input  logic [31:0] s_tdata,
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: [0] clear_screen, [9:1] write_address, [17:10] write_data, [23:18] zero.
	output logic [23:0] m_tdata,
	output logic        m_tlast
);

	logic                        pal_q;
	logic                        s1_valid_q;
	tocw_pkg::item_t             item_s1;
	logic                        plan_take;
	tocw_pkg::plan_t             plan;
	tocw_pkg::res_t              res;
	logic [tocw_pkg::CUR_W-1:0]  cursor;

	// Configuration: a single mode register, read back at the same address.
	assign pready = 1'b1;
	assign prdata = (paddr == tocw_pkg::REG_PAL_MODE) ? {31'd0, pal_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (paddr == tocw_pkg::REG_PAL_MODE)) begin
			pal_q <= pwdata[0];
		end
	end

	// Input register. It frees itself in the same cycle its item moves on, so the
	// stream keeps one transaction per cycle while the sequencer keeps up.
	assign s_tready = !s1_valid_q || plan_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			s1_valid_q <= 1'b1;
		end else if (plan_take) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= tocw_pkg::item_t'(s_tdata[25:0]);
		end
	end

	// The cursor advances when the sequencer takes the item's plan.
	tocw_cursor u_cursor (
		.clk      (clk),
		.arst_n   (arst_n),
		.pal_mode (pal_q),
		.item     (item_s1),
		.take     (plan_take),
		.plan     (plan),
		.cursor   (cursor)
	);

	tocw_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.plan       (plan),
		.plan_valid (s1_valid_q),
		.plan_take  (plan_take),
		.res        (res),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready)
	);

	assign m_tdata = {6'd0, res.write_data, res.write_address, res.clear_screen};
	assign m_tlast = res.last;

	// A clear-screen transaction always has its character write after it.
	a_clear_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res.clear_screen) |-> !m_tlast)
		else $error("clear-screen transaction marked last");

	a_clear_then_write: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && res.clear_screen) |=> (m_tvalid && !res.clear_screen))
		else $error("clear-screen transaction not followed by its write");

	// The cursor never leaves the larger of the two screens.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor < tocw_pkg::CUR_W'(tocw_pkg::ROWS_PAL * tocw_pkg::COLUMNS))
		else $error("cursor beyond screen");

endmodule

// File: design/tocw_cursor.sv
module tocw_cursor (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     pal_mode,
	input  tocw_pkg::item_t          item,
	input  logic                     take,
	output tocw_pkg::plan_t          plan,
	output logic [tocw_pkg::CUR_W-1:0] cursor
);

	localparam int CUR_W = tocw_pkg::CUR_W;
	localparam int ROW_W = tocw_pkg::ROW_W;
	localparam int POS_W = tocw_pkg::POS_W;

	logic [CUR_W-1:0]              cursor_q;
	logic [CUR_W-1:0]              cursor_next;
	logic [tocw_pkg::ROWS_PAL-2:0] row_ge;
	logic [ROW_W-1:0]              cur_row;
	logic [ROW_W-1:0]              row_inc;
	logic [ROW_W-1:0]              row_wrap;
	logic [ROW_W-1:0]              rows_n;
	logic [CUR_W:0]                cells;
	logic [CUR_W:0]                cur_inc;
	logic [POS_W-1:0]              set_pos;

	// The row of the cursor is the number of row starts after row 0 at or below it.
	always_comb begin
		for (int k = 1; k < tocw_pkg::ROWS_PAL; k++) begin
			row_ge[k-1] = cursor_q >= CUR_W'(k * tocw_pkg::COLUMNS);
		end
	end

	assign cur_row  = ROW_W'($countones(row_ge));
	assign rows_n   = pal_mode ? ROW_W'(tocw_pkg::ROWS_PAL) : ROW_W'(tocw_pkg::ROWS_NTSC);
	assign cells    = pal_mode ? (CUR_W+1)'(tocw_pkg::ROWS_PAL * tocw_pkg::COLUMNS)
	                           : (CUR_W+1)'(tocw_pkg::ROWS_NTSC * tocw_pkg::COLUMNS);
	assign row_inc  = cur_row + ROW_W'(1);
	// Row index stays below twice the row count, so one subtraction wraps it.
	assign row_wrap = (row_inc >= rows_n) ? (row_inc - rows_n) : row_inc;
	assign cur_inc  = {1'b0, cursor_q} + (CUR_W+1)'(1);
	assign set_pos  = POS_W'(item.row * tocw_pkg::COLUMNS) + POS_W'(item.column);

	always_comb begin
		cursor_next = cursor_q;
		plan        = '0;
		case (item.mode)
			tocw_pkg::MODE_PUT: begin
				if (item.char_code == tocw_pkg::CHAR_CR) begin
					cursor_next = CUR_W'(cur_row * tocw_pkg::COLUMNS);
				end else if (item.char_code == tocw_pkg::CHAR_LF) begin
					cursor_next = CUR_W'(row_wrap * tocw_pkg::COLUMNS);
				end else begin
					plan.clr   = (cursor_q == '0);
					plan.base  = tocw_pkg::ADDR_W'(cursor_q);
					plan.data  = item.char_code;
					plan.count = tocw_pkg::CNT_W'(1);
					cursor_next = (cur_inc >= cells) ? CUR_W'(cur_inc - cells) : CUR_W'(cur_inc);
				end
			end
			tocw_pkg::MODE_SET: begin
				if (set_pos < POS_W'(cells)) begin
					cursor_next = CUR_W'(set_pos);
				end
			end
			tocw_pkg::MODE_CLR: begin
				if (item.row < 8'(rows_n)) begin
					plan.base  = tocw_pkg::ADDR_W'(item.row * tocw_pkg::COLUMNS);
					plan.data  = tocw_pkg::CHAR_SPACE;
					plan.count = tocw_pkg::CNT_W'(tocw_pkg::LINE_CNT);
				end
			end
			default: begin
				cursor_next = cursor_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (take) begin
			cursor_q <= cursor_next;
		end
	end

	assign cursor = cursor_q;

endmodule

// File: design/tocw_seq.sv
module tocw_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  tocw_pkg::plan_t plan,
	input  logic            plan_valid,
	output logic            plan_take,
	output tocw_pkg::res_t  res,
	output logic            res_valid,
	input  logic            res_ready
);

	logic                          busy_q;
	logic                          clr_q;
	logic [tocw_pkg::ADDR_W-1:0]   addr_q;
	logic [7:0]                    data_q;
	logic [tocw_pkg::CNT_W-1:0]    rem_q;
	logic                          ovalid_q;
	tocw_pkg::res_t                ores_q;
	logic                          load;
	logic                          final_res;
	logic                          start;

	assign load      = busy_q && (!ovalid_q || res_ready);
	assign final_res = !clr_q && (rem_q == tocw_pkg::CNT_W'(1));
	assign plan_take = plan_valid && (!busy_q || (load && final_res));
	// A new run starts only when the sequencer is idle or finishing its final result.
	assign start     = plan_take && (plan.count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			clr_q    <= 1'b0;
			rem_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (res_ready) begin
				ovalid_q <= 1'b0;
			end
			if (start) begin
				busy_q <= 1'b1;
			end else if (load && final_res) begin
				busy_q <= 1'b0;
			end
			if (start) begin
				clr_q <= plan.clr;
				rem_q <= plan.count;
			end else if (load) begin
				if (clr_q) begin
					clr_q <= 1'b0;
				end else begin
					rem_q <= rem_q - tocw_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (clr_q) begin
				ores_q <= '{last: 1'b0, write_data: '0, write_address: '0, clear_screen: 1'b1};
			end else begin
				ores_q <= '{last: final_res, write_data: data_q, write_address: addr_q,
				            clear_screen: 1'b0};
			end
		end
		if (start) begin
			addr_q <= plan.base;
			data_q <= plan.data;
		end else if (load && !clr_q) begin
			addr_q <= addr_q + tocw_pkg::ADDR_W'(1);
		end
	end

	assign res       = ores_q;
	assign res_valid = ovalid_q;

endmodule

// File: tb/text_overlay_cursor_writer_tb.sv
`timescale 1ns / 1ps

// The testbench feeds the cursor writer through its input stream, writes pal_mode through
// the APB port while the block is idle, and checks every display-memory write against the
// script's typed writes or, for untyped items, a cursor model in step with accepted inputs.
module text_overlay_cursor_writer_tb;

	// Mode code that the block must ignore.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Cycles allowed after the last expected write before the block counts as idle.
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 20;
	localparam int PHASES        = 4;
	// A correct run takes well under 200 us even with every clear-line stalled.
	localparam int LIMIT_NS      = 2_000_000;

	// One row of the directed script. A configuration row writes pal_mode. An item row
	// either carries its expected writes typed in (typed set, up to two of them) or
	// leaves them to the cursor model.
	typedef struct packed {
		logic            is_cfg;
		logic            pal_val;
		tocw_pkg::item_t it;
		logic            typed;
		logic [1:0]      n;
		tocw_pkg::res_t  r0;
		tocw_pkg::res_t  r1;
	} step_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tlast;

	// Shadow of the block's cursor and of pal_mode, plus the writes still owed by the block.
	int             shadow_cursor = 0;
	logic           shadow_pal    = 1'b0;
	tocw_pkg::res_t expected_writes[$];
	tocw_pkg::res_t fresh[$];

	// When quiet is set, neither side of the stream idles any more.
	logic quiet  = 1'b0;
	int   errors = 0;

	text_overlay_cursor_writer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic tocw_pkg::res_t wr(input logic [tocw_pkg::ADDR_W-1:0] addr,
			input logic [7:0] data, input logic fin);
		tocw_pkg::res_t r;
		r.clear_screen  = 1'b0;
		r.write_address = addr;
		r.write_data    = data;
		r.last          = fin;
		return r;
	endfunction

	// A clear-screen transaction has zero address and data and is never the last one.
	function automatic tocw_pkg::res_t cls();
		tocw_pkg::res_t r;
		r = '0;
		r.clear_screen = 1'b1;
		return r;
	endfunction

	function automatic tocw_pkg::item_t mk_item(input logic [1:0] m, input logic [7:0] ch,
			input logic [7:0] col, input logic [7:0] rw);
		tocw_pkg::item_t it;
		it.mode      = m;
		it.char_code = ch;
		it.column    = col;
		it.row       = rw;
		return it;
	endfunction

	function automatic step_t any_op(input logic [1:0] m, input logic [7:0] ch,
			input logic [7:0] col, input logic [7:0] rw);
		step_t st;
		st    = '0;
		st.it = mk_item(m, ch, col, rw);
		return st;
	endfunction

	function automatic step_t typed_op(input logic [1:0] m, input logic [7:0] ch,
			input logic [7:0] col, input logic [7:0] rw, input int n,
			input tocw_pkg::res_t a, input tocw_pkg::res_t b);
		step_t st;
		st       = any_op(m, ch, col, rw);
		st.typed = 1'b1;
		st.n     = n[1:0];
		st.r0    = a;
		st.r1    = b;
		return st;
	endfunction

	function automatic step_t cfg_step(input logic v);
		step_t st;
		st         = '0;
		st.is_cfg  = 1'b1;
		st.pal_val = v;
		return st;
	endfunction

	// Cursor model: advances the shadow cursor for one input transaction and leaves the
	// writes it causes in fresh.
	function automatic void predict_writes(input tocw_pkg::item_t it);
		int rows;
		int cells;
		int base;
		int i;
		fresh.delete();
		rows  = shadow_pal ? tocw_pkg::ROWS_PAL : tocw_pkg::ROWS_NTSC;
		cells = tocw_pkg::COLUMNS * rows;
		case (it.mode)
			tocw_pkg::MODE_PUT: begin
				if (it.char_code == tocw_pkg::CHAR_CR) begin
					shadow_cursor = (shadow_cursor / tocw_pkg::COLUMNS) * tocw_pkg::COLUMNS;
				end else if (it.char_code == tocw_pkg::CHAR_LF) begin
					shadow_cursor = (((shadow_cursor / tocw_pkg::COLUMNS) + 1) % rows)
							* tocw_pkg::COLUMNS;
				end else begin
					// Printing at the home position wipes the screen first. After a switch
					// to the smaller screen the cursor may still sit past its end; the
					// write uses it as it is and the wrap below pulls it back.
					if (shadow_cursor == 0)
						fresh.push_back(cls());
					fresh.push_back(wr(shadow_cursor[tocw_pkg::ADDR_W-1:0], it.char_code,
							1'b1));
					shadow_cursor = (shadow_cursor + 1) % cells;
				end
			end
			tocw_pkg::MODE_SET: begin
				// The column is not limited to the screen width, only the cell index is.
				base = it.row * tocw_pkg::COLUMNS + it.column;
				if (base < cells)
					shadow_cursor = base;
			end
			tocw_pkg::MODE_CLR: begin
				if (it.row < rows) begin
					base = it.row * tocw_pkg::COLUMNS;
					for (i = 0; i < tocw_pkg::LINE_CNT; i++)
						fresh.push_back(wr(tocw_pkg::ADDR_W'(base + i), tocw_pkg::CHAR_SPACE,
								i == tocw_pkg::LINE_CNT - 1));
				end
			end
			default: begin
			end
		endcase
	endfunction

	// Random input transaction. Most are well-formed puts and moves within the current
	// screen; the rest are off-screen requests, bottom overruns and the unused mode.
	function automatic tocw_pkg::item_t random_item();
		tocw_pkg::item_t it;
		int              pick;
		int              rows;
		pick = $urandom_range(0, 99);
		rows = shadow_pal ? tocw_pkg::ROWS_PAL : tocw_pkg::ROWS_NTSC;
		it   = mk_item(tocw_pkg::MODE_PUT, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		if (pick < 50) begin
		end else if (pick < 58) begin
			it.char_code = tocw_pkg::CHAR_CR;
		end else if (pick < 66) begin
			it.char_code = tocw_pkg::CHAR_LF;
		end else if (pick < 78) begin
			it.mode   = tocw_pkg::MODE_SET;
			it.row    = 8'($urandom_range(0, rows - 1));
			it.column = 8'($urandom_range(0, tocw_pkg::COLUMNS - 1));
		end else if (pick < 86) begin
			it.mode = tocw_pkg::MODE_SET;
		end else if (pick < 92) begin
			it.mode = tocw_pkg::MODE_CLR;
			it.row  = 8'($urandom_range(0, rows - 1));
		end else if (pick < 96) begin
			it.mode = tocw_pkg::MODE_CLR;
		end else begin
			it.mode = MODE_UNUSED;
		end
		return it;
	endfunction

	task automatic note_error(input string what);
		errors++;
		$display("%0t ns: %s", $time, what);
	endtask

	// Presents one input transaction, optionally after a short gap, and books the writes
	// it causes at the edge where it is accepted. tvalid stays high into the next call so
	// that back-to-back transactions see no bubble.
	task automatic send_item(input step_t st);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, st.it};
		do @(posedge clk); while (!s_tready);
		predict_writes(st.it);
		if (st.typed) begin
			if (st.n > 0)
				expected_writes.push_back(st.r0);
			if (st.n > 1)
				expected_writes.push_back(st.r1);
		end else begin
			expected_writes = {expected_writes, fresh};
		end
	endtask

	// pal_mode changes only once every owed write has come out and the block has had time
	// to finish anything that causes no write.
	task automatic set_pal(input logic v);
		s_tvalid <= 1'b0;
		while (expected_writes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= tocw_pkg::REG_PAL_MODE;
		pwdata  <= {31'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		shadow_pal = v;
	endtask

	// Stimulus: reset, the directed script, then random phases that alternate the screen
	// mode. The last phase runs with no idling on either side.
	initial begin : stimulus
		step_t script[$];
		step_t st;
		int    ph;
		int    k;

		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= tocw_pkg::REG_PAL_MODE;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// NTSC after reset. A print at home clears the screen first, then cells fill in order.
		script.push_back(typed_op(tocw_pkg::MODE_PUT, 8'h41, 8'h00, 8'h00, 2, cls(),
				wr(9'd0, 8'h41, 1'b1)));
		script.push_back(typed_op(tocw_pkg::MODE_PUT, 8'hFF, 8'hFF, 8'hFF, 1,
				wr(9'd1, 8'hFF, 1'b1), '0));
		script.push_back(typed_op(tocw_pkg::MODE_PUT, 8'h00, 8'h00, 8'h00, 1,
				wr(9'd2, 8'h00, 1'b1), '0));
		// Carriage return goes home again, so the next print clears once more.
		script.push_back(typed_op(tocw_pkg::MODE_PUT, tocw_pkg::CHAR_CR, 8'h00, 8'h00, 0,
				'0, '0));
		script.push_back(typed_op(tocw_pkg::MODE_PUT, 8'h55, 8'h00, 8'h00, 2, cls(),
				wr(9'd0, 8'h55, 1'b1)));
		script.push_back(typed_op(tocw_pkg::MODE_PUT, tocw_pkg::CHAR_LF, 8'h00, 8'h00, 0,
				'0, '0));
		// Last cell of the screen; printing there wraps the cursor home.
		script.push_back(typed_op(tocw_pkg::MODE_SET, 8'h00, 8'd29, 8'd11, 0, '0, '0));
		script.push_back(typed_op(tocw_pkg::MODE_PUT, 8'h7E, 8'h00, 8'h00, 1,
				wr(9'd359, 8'h7E, 1'b1), '0));
		script.push_back(typed_op(tocw_pkg::MODE_PUT, 8'h31, 8'h00, 8'h00, 2, cls(),
				wr(9'd0, 8'h31, 1'b1)));
		// Off-screen moves are dropped; a column past the width is fine while the cell fits.
		script.push_back(typed_op(tocw_pkg::MODE_SET, 8'h00, 8'd0, 8'd12, 0, '0, '0));
		script.push_back(typed_op(tocw_pkg::MODE_SET, 8'hFF, 8'hFF, 8'hFF, 0, '0, '0));
		script.push_back(typed_op(tocw_pkg::MODE_SET, 8'h00, 8'hFF, 8'h00, 0, '0, '0));
		script.push_back(typed_op(tocw_pkg::MODE_PUT, 8'h42, 8'h00, 8'h00, 1,
				wr(9'd255, 8'h42, 1'b1), '0));
		// Clear-line on the top row, then rows past the bottom, then the unused mode.
		script.push_back(any_op(tocw_pkg::MODE_CLR, 8'h00, 8'h00, 8'd0));
		script.push_back(typed_op(tocw_pkg::MODE_CLR, 8'h00, 8'h00, 8'd12, 0, '0, '0));
		script.push_back(typed_op(tocw_pkg::MODE_CLR, 8'hFF, 8'hFF, 8'hFF, 0, '0, '0));
		script.push_back(typed_op(MODE_UNUSED, 8'hFF, 8'hFF, 8'hFF, 0, '0, '0));
		// Line feed on the bottom row wraps to the top.
		script.push_back(typed_op(tocw_pkg::MODE_SET, 8'h00, 8'd29, 8'd11, 0, '0, '0));
		script.push_back(typed_op(tocw_pkg::MODE_PUT, tocw_pkg::CHAR_LF, 8'h00, 8'h00, 0,
				'0, '0));
		// PAL: the last cell and the bottom row move down to 449 and row 14.
		script.push_back(cfg_step(1'b1));
		script.push_back(typed_op(tocw_pkg::MODE_SET, 8'h00, 8'd29, 8'd14, 0, '0, '0));
		script.push_back(typed_op(tocw_pkg::MODE_PUT, 8'h80, 8'h00, 8'h00, 1,
				wr(9'd449, 8'h80, 1'b1), '0));
		script.push_back(any_op(tocw_pkg::MODE_CLR, 8'h00, 8'h00, 8'd14));
		script.push_back(typed_op(tocw_pkg::MODE_CLR, 8'h00, 8'h00, 8'd15, 0, '0, '0));
		// Cursor left below the NTSC screen by a mode switch: the print lands at the old
		// cell and the advance wraps modulo 360.
		script.push_back(typed_op(tocw_pkg::MODE_SET, 8'h00, 8'd10, 8'd13, 0, '0, '0));
		script.push_back(cfg_step(1'b0));
		script.push_back(typed_op(tocw_pkg::MODE_PUT, 8'h61, 8'h00, 8'h00, 1,
				wr(9'd400, 8'h61, 1'b1), '0));
		// Same situation, left by a line feed instead: row 13 plus one wraps to row 2.
		script.push_back(cfg_step(1'b1));
		script.push_back(typed_op(tocw_pkg::MODE_SET, 8'h00, 8'd10, 8'd13, 0, '0, '0));
		script.push_back(cfg_step(1'b0));
		script.push_back(typed_op(tocw_pkg::MODE_PUT, tocw_pkg::CHAR_LF, 8'h00, 8'h00, 0,
				'0, '0));
		script.push_back(typed_op(tocw_pkg::MODE_PUT, 8'h33, 8'h00, 8'h00, 1,
				wr(9'd60, 8'h33, 1'b1), '0));

		foreach (script[i]) begin
			if (script[i].is_cfg)
				set_pal(script[i].pal_val);
			else
				send_item(script[i]);
		end

		for (ph = 0; ph < PHASES; ph++) begin
			set_pal(~ph[0]);
			quiet = (ph == PHASES - 1);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				st    = '0;
				st.it = random_item();
				send_item(st);
			end
		end
		s_tvalid <= 1'b0;

		// Drain every owed write, then give the block time to show any stray extra one.
		while (expected_writes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES * 4) @(posedge clk);
		if (errors == 0)
			$display("text_overlay_cursor_writer: match");
		else
			$display("text_overlay_cursor_writer: mismatch");
		$finish;
	end

	// Write-side receiver: stall bursts are separated by ready stretches of random length
	// and stop once the run goes quiet.
	initial begin : receiver
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(0, 7)) @(posedge clk);
		end
	end

	// Every accepted write transaction is matched field by field against the oldest one owed.
	// m_tdata holds clear_screen in bit 0, the address in bits 9:1 and the data in 17:10.
	always @(posedge clk) begin : check_writes
		tocw_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_writes.size() == 0) begin
				note_error($sformatf("write transaction with none owed: tdata %h tlast %b",
						m_tdata, m_tlast));
			end else begin
				want = expected_writes.pop_front();
				if (m_tdata[0] !== want.clear_screen)
					note_error($sformatf("clear_screen %b, wanted %b", m_tdata[0],
							want.clear_screen));
				if (m_tdata[9:1] !== want.write_address)
					note_error($sformatf("write_address %0d, wanted %0d", m_tdata[9:1],
							want.write_address));
				if (m_tdata[17:10] !== want.write_data)
					note_error($sformatf("write_data %h, wanted %h at address %0d",
							m_tdata[17:10], want.write_data, want.write_address));
				if (m_tlast !== want.last)
					note_error($sformatf("tlast %b, wanted %b at address %0d", m_tlast,
							want.last, want.write_address));
			end
		end
	end

	initial begin : watchdog
		#(LIMIT_NS);
		$display("text_overlay_cursor_writer: mismatch");
		$finish;
	end

endmodule
